### rtl/rect_polygon_clipper_defines.svh
// ---------------------------------------------------------------------------
// rect_polygon_clipper_defines.svh
// Assertion macros shared by the clipper's checker.
// ---------------------------------------------------------------------------
`ifndef RECT_POLYGON_CLIPPER_DEFINES_SVH
`define RECT_POLYGON_CLIPPER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define RPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define RPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// holds in the cycle after reset is seen
`define RPC_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### rtl/rpc_pkg.sv
// ---------------------------------------------------------------------------
// rpc_pkg
// Shared constants and types of the rectangle polygon clipper.
// ---------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned STAGE_COUNT    = 4;
  localparam int unsigned CFG_IDX_BITS   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_A_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_A_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_B_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_B_Y = 2'd3;

  // clip cell sequencer
  typedef enum logic [3:0] {
    ST_IDLE,    // waiting for a word
    ST_VTX,     // vertex: record first or set up edge
    ST_CLS,     // close: set up closing edge
    ST_MUL,     // magnitudes and product
    ST_DIV,     // one quotient bit a cycle
    ST_FIN,     // sign and truncation fix-up
    ST_EMIT_X,  // send crossing point
    ST_EMIT_V,  // send edge end vertex
    ST_EMIT_C   // send close marker
  } cell_state_t;

endpackage

`default_nettype wire

### rtl/rect_polygon_clipper.sv
// ---------------------------------------------------------------------------
// rect_polygon_clipper
// Streaming Sutherland-Hodgman clipper of a closed polygon to a rectangle.
// ---------------------------------------------------------------------------
// Vertices enter one word at a time, tlast on the final one, and pass a row
// of four clip cells (x = corner_a_x, y = corner_b_y, x = corner_b_x,
// y = corner_a_y) and an output hold stage. Each cell works on one word at a
// time and takes no new word until it is done with the last; an edge
// crossing its line goes through the cell's bit-serial divider, and the
// slowest cell sets the throughput. Results leave in order with tlast on the
// last vertex; a polygon clipped away gives one word with tuser set and zero
// coordinates. Corners are to be written through the cfg port only while the
// block is idle; the block itself does not enforce this. No clearing pass
// after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module rect_polygon_clipper #(
  parameter int unsigned COORD_BITS = rpc_pkg::COORD_BITS_DEF,
  localparam int unsigned DW = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [COORD_BITS-1:0]             cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [DW-1:0]                     s_axis_tdata,  // vertex_x, vertex_y
  input  wire logic                              s_axis_tlast,  // last_vertex
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [DW-1:0]                          m_axis_tdata,  // out_x, out_y
  output logic                                   m_axis_tlast,  // last_out
  output logic                                   m_axis_tuser   // empty_poly
);
  import rpc_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  logic signed [CB-1:0] a_x, a_y, b_x, b_y;

  // corner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_x <= '0;
      a_y <= '0;
      b_x <= '0;
      b_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A_X: a_x <= cfg_data;
        CFG_A_Y: a_y <= cfg_data;
        CFG_B_X: b_x <= cfg_data;
        CFG_B_Y: b_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // links between cells; link 0 is the input
  logic                 lv [STAGE_COUNT+1];
  logic                 lr [STAGE_COUNT+1];
  logic signed [CB-1:0] lx [STAGE_COUNT+1];
  logic signed [CB-1:0] ly [STAGE_COUNT+1];
  logic                 lvt[STAGE_COUNT+1];
  logic                 lc [STAGE_COUNT+1];

  assign lv[0]         = s_axis_tvalid;
  assign s_axis_tready = lr[0];
  assign lx[0]         = s_axis_tdata[CB-1:0];
  assign ly[0]         = s_axis_tdata[2*CB-1:CB];
  assign lvt[0]        = 1'b1;
  assign lc[0]         = s_axis_tlast;

  for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_cell
    rpc_cell #(.COORD_BITS(CB), .STAGE(k)) u_cell (
      .clk, .rst,
      .a_x, .a_y, .b_x, .b_y,
      .in_valid (lv[k]),   .in_ready (lr[k]),
      .in_x     (lx[k]),   .in_y     (ly[k]),
      .in_vert  (lvt[k]),  .in_close (lc[k]),
      .out_valid(lv[k+1]), .out_ready(lr[k+1]),
      .out_x    (lx[k+1]), .out_y    (ly[k+1]),
      .out_close(lc[k+1])
    );
    assign lvt[k+1] = !lc[k+1];
  end

  logic signed [CB-1:0] ox, oy;
  logic                 unused_vert;
  assign unused_vert = lvt[STAGE_COUNT];

  rpc_sink #(.COORD_BITS(CB)) u_sink (
    .clk, .rst,
    .in_valid (lv[STAGE_COUNT]), .in_ready(lr[STAGE_COUNT]),
    .in_x     (lx[STAGE_COUNT]), .in_y    (ly[STAGE_COUNT]),
    .in_close (lc[STAGE_COUNT]),
    .out_valid(m_axis_tvalid),   .out_ready(m_axis_tready),
    .out_x    (ox),              .out_y    (oy),
    .out_last (m_axis_tlast),    .out_empty(m_axis_tuser)
  );

  assign m_axis_tdata = DW'({oy, ox});

endmodule

`default_nettype wire

### rtl/rpc_cell.sv
// ---------------------------------------------------------------------------
// rpc_cell
// One clip stage: keeps first and previous vertex, clips each edge against
// one rectangle side and forwards vertices and the close marker.
// ---------------------------------------------------------------------------
`default_nettype none

module rpc_cell #(
  parameter int unsigned COORD_BITS = rpc_pkg::COORD_BITS_DEF,
  parameter int unsigned STAGE      = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic signed [COORD_BITS-1:0] a_x,
  input  wire logic signed [COORD_BITS-1:0] a_y,
  input  wire logic signed [COORD_BITS-1:0] b_x,
  input  wire logic signed [COORD_BITS-1:0] b_y,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  input  wire logic                         in_vert,
  input  wire logic                         in_close,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic                              out_close
);
  import rpc_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned PW   = 2 * (CB + 1);
  localparam int unsigned CW   = $clog2(PW + 1);
  localparam bit          EVEN = (STAGE % 2) == 0;

  cell_state_t state, state_next;

  logic signed [CB-1:0] tx, ty, first_x, first_y, prev_x, prev_y;
  logic signed [CB-1:0] e_vx, e_vy, a1, b1, ln, res;
  logic                 tclose, has_first, prev_in, e_vin, closing, neg;
  logic [PW-1:0]        pq;
  logic [CB:0]          rem, dd;
  logic [CW-1:0]        cnt;

  // clip line and kept side for this stage
  logic signed [CB-1:0] ln_now;
  logic                 keep_gt;
  always_comb begin
    case (STAGE)
      0: begin ln_now = a_x; keep_gt = (a_x < b_x);  end
      1: begin ln_now = b_y; keep_gt = !(a_y < b_y); end
      2: begin ln_now = b_x; keep_gt = !(a_x < b_x); end
      default: begin ln_now = a_y; keep_gt = (a_y < b_y); end
    endcase
  end

  // strict inside tests for the new vertex and the first vertex
  logic signed [CB-1:0] pt, pf;
  logic                 vin_t, vin_f;
  assign pt    = EVEN ? tx : ty;
  assign pf    = EVEN ? first_x : first_y;
  assign vin_t = keep_gt ? (pt > ln_now) : (pt < ln_now);
  assign vin_f = keep_gt ? (pf > ln_now) : (pf < ln_now);

  // crossing arithmetic operands
  logic signed [CB-1:0] a2, b2;
  logic signed [CB:0]   da, db, dt;
  logic [CB:0]          mda, mdb, mdt;
  logic [PW-1:0]        prod;
  logic                 zero;
  assign a2   = EVEN ? e_vx : e_vy;
  assign b2   = EVEN ? e_vy : e_vx;
  assign da   = {a2[CB-1], a2} - {a1[CB-1], a1};
  assign db   = {b2[CB-1], b2} - {b1[CB-1], b1};
  assign dt   = {ln[CB-1], ln} - {a1[CB-1], a1};
  assign mda  = da[CB] ? (CB+1)'(-da) : da;
  assign mdb  = db[CB] ? (CB+1)'(-db) : db;
  assign mdt  = dt[CB] ? (CB+1)'(-dt) : dt;
  assign prod = mdb * mdt;
  assign zero = (da == '0) || (db == '0) || (dt == '0);

  // restoring divide step
  logic [CB+1:0] rem_sh, rem_sub;
  logic          ge;
  assign rem_sh  = {rem, pq[PW-1]};
  assign ge      = rem_sh >= {1'b0, dd};
  assign rem_sub = rem_sh - {1'b0, dd};

  // quotient applied to the start coordinate, truncated toward zero
  logic signed [PW+1:0] b1x, qx, base0, base;
  assign b1x   = {{(PW+2-CB){b1[CB-1]}}, b1};
  assign qx    = {2'b00, pq};
  assign base0 = neg ? (b1x - qx) : (b1x + qx);
  always_comb begin
    base = base0;
    if (rem != '0) begin
      if (!neg && base0 < 0) base = base0 + 1;
      else if (neg && base0 > 0) base = base0 - 1;
    end
  end

  function automatic cell_state_t after_edge(input logic cl, input logic tc);
    if (cl) return ST_EMIT_C;
    else if (tc) return ST_CLS;
    else return ST_IDLE;
  endfunction

  function automatic cell_state_t dispatch(input logic p, input logic v,
                                           input logic cl, input logic tc);
    if (p && v) return ST_EMIT_V;
    else if (p != v) return ST_MUL;
    else return after_edge(cl, tc);
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = in_vert ? ST_VTX : ST_CLS;
      ST_VTX:    state_next = has_first ? dispatch(prev_in, vin_t, 1'b0, tclose)
                                        : after_edge(1'b0, tclose);
      ST_CLS:    state_next = has_first ? dispatch(prev_in, vin_f, 1'b1, tclose)
                                        : ST_EMIT_C;
      ST_MUL:    state_next = zero ? ST_FIN : ST_DIV;
      ST_DIV:    if (cnt == CW'(1)) state_next = ST_FIN;
      ST_FIN:    state_next = ST_EMIT_X;
      ST_EMIT_X: if (out_ready) state_next = e_vin ? ST_EMIT_V : after_edge(closing, tclose);
      ST_EMIT_V: if (out_ready) state_next = after_edge(closing, tclose);
      ST_EMIT_C: if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = 1'b0;
    out_x     = e_vx;
    out_y     = e_vy;
    out_close = 1'b0;
    case (state)
      ST_EMIT_X: begin
        out_valid = 1'b1;
        out_x     = EVEN ? ln : res;
        out_y     = EVEN ? res : ln;
      end
      ST_EMIT_V: out_valid = 1'b1;
      ST_EMIT_C: begin
        out_valid = 1'b1;
        out_x     = '0;
        out_y     = '0;
        out_close = 1'b1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      has_first <= 1'b0;
      closing   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_VTX) begin
        has_first <= 1'b1;
        closing   <= 1'b0;
      end
      if (state == ST_CLS) begin
        has_first <= 1'b0;
        closing   <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_valid) begin
        tx     <= in_x;
        ty     <= in_y;
        tclose <= in_close;
      end
      ST_VTX: begin
        if (!has_first) begin
          first_x <= tx;
          first_y <= ty;
        end
        e_vx    <= tx;
        e_vy    <= ty;
        e_vin   <= vin_t;
        a1      <= EVEN ? prev_x : prev_y;
        b1      <= EVEN ? prev_y : prev_x;
        ln      <= ln_now;
        prev_x  <= tx;
        prev_y  <= ty;
        prev_in <= vin_t;
      end
      ST_CLS: begin
        e_vx  <= first_x;
        e_vy  <= first_y;
        e_vin <= vin_f;
        a1    <= EVEN ? prev_x : prev_y;
        b1    <= EVEN ? prev_y : prev_x;
        ln    <= ln_now;
      end
      ST_MUL: begin
        neg <= (db[CB] ^ dt[CB]) ^ da[CB];
        dd  <= mda;
        rem <= '0;
        pq  <= zero ? '0 : prod;
        cnt <= CW'(PW);
      end
      ST_DIV: begin
        rem <= ge ? rem_sub[CB:0] : rem_sh[CB:0];
        pq  <= {pq[PW-2:0], ge};
        cnt <= cnt - CW'(1);
      end
      ST_FIN: res <= base[CB-1:0];
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/rpc_sink.sv
// ---------------------------------------------------------------------------
// rpc_sink
// Holds the newest clipped vertex until the next one or the close shows
// whether it ends the polygon; drives the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rpc_sink #(
  parameter int unsigned COORD_BITS = rpc_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_x,
  input  wire logic signed [COORD_BITS-1:0] in_y,
  input  wire logic                         in_close,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic                              out_last,
  output logic                              out_empty
);
  import rpc_pkg::*;

  logic signed [COORD_BITS-1:0] hold_x, hold_y;
  logic                         any_emitted;
  logic                         take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      any_emitted <= 1'b0;
    end else begin
      if (take) begin
        out_valid   <= in_close || any_emitted;
        any_emitted <= !in_close;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_x     <= any_emitted ? hold_x : '0;
      out_y     <= any_emitted ? hold_y : '0;
      out_last  <= in_close;
      out_empty <= in_close && !any_emitted;
      if (!in_close) begin
        hold_x <= in_x;
        hold_y <= in_y;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rpc_checker.sv
// ---------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the clipper's result stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rect_polygon_clipper_defines.svh"

module rpc_checker #(
  parameter int unsigned COORD_BITS = rpc_pkg::COORD_BITS_DEF,
  localparam int unsigned DW = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          m_axis_tvalid,
  input wire logic          m_axis_tready,
  input wire logic [DW-1:0] m_axis_tdata,
  input wire logic          m_axis_tlast,
  input wire logic          m_axis_tuser
);

  // nothing pending straight after reset
  `RPC_ASSERT_RST(a_idle_after_rst, !m_axis_tvalid, "result valid after reset")

  // an empty marker closes its polygon and carries zero coordinates
  `RPC_ASSERT_IMP(a_empty_form, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "bad empty word")

  // a stalled word holds
  `RPC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled word changed")

endmodule

bind rect_polygon_clipper rpc_checker #(.COORD_BITS(COORD_BITS)) u_rpc_checker (.*);

`default_nettype wire
